>>> rtl/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// shared types, constants and word-scan helpers of the bitmap id allocator
// ----------------------------------------------------------------------------
package bia_pkg;

  // pool bounds, ids run from MinId up to MaxIds - 1
  localparam int unsigned MaxIds   = 1024;
  localparam int unsigned MinId    = 1;
  localparam int unsigned Cap      = MaxIds - MinId;

  localparam int unsigned IdW      = 10;
  localparam int unsigned CntW     = 11;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StatW    = 2;

  // bitmap kept as words in a ram, MaxIds is a whole number of words
  localparam int unsigned WordW    = 32;
  localparam int unsigned BitW     = $clog2(WordW);
  localparam int unsigned NumWords = MaxIds / WordW;
  localparam int unsigned AddrW    = $clog2(NumWords);

  typedef enum logic [KindW-1:0] {
    KIND_QUERY = 3'd0,
    KIND_TAKE  = 3'd1,
    KIND_FREE  = 3'd2,
    KIND_ALLOC = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LOW,
    S_HIGH,
    S_RESP
  } fsm_e;

  typedef logic [WordW-1:0] word_t;

  // position of the lowest set bit, zero if none
  function automatic logic [BitW-1:0] lowest_one(word_t w);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (w[i]) pos = BitW'(i);
    end
    return pos;
  endfunction

  // position of the highest set bit, zero if none
  function automatic logic [BitW-1:0] highest_one(word_t w);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = 0; i < WordW; i++) begin
      if (w[i]) pos = BitW'(i);
    end
    return pos;
  endfunction

  // bits of a word whose ids lie below the pool, treated as taken
  function automatic word_t below_min(logic [AddrW-1:0] a);
    word_t m;
    m = '0;
    for (int i = 0; i < WordW; i++) begin
      m[i] = (CntW'({a, BitW'(i)}) < CntW'(MinId));
    end
    return m;
  endfunction

endpackage

>>> rtl/bia_ram.sv
// ----------------------------------------------------------------------------
// bia_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// used/free bitmap of identifiers with query, mark, allocate and clear
// ----------------------------------------------------------------------------
// the bitmap lives in a ram of 32-bit words with one valid flag per word, so
// reset and clear all take effect at once with no clearing pass. one
// transaction is handled at a time. query, mark taken and mark free pass
// from the accept through an evaluate step and a response step; clear,
// unknown kinds and rejected requests go from the accept straight to the
// response step. allocate is bound by the single ram read port and one
// shared word scanner that looks at one word per cycle: when the next-id mark
// is free it is taken and a downward search looks for the highest taken id;
// when it is taken, or past the top, the lowest free id is searched upward
// first. a stalled output holds the transaction in its response step. a
// finished result waits in the output register while the next transaction
// is taken in.
module bitmap_id_allocator
  import bia_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] ident, rest zero
  input  logic [7:0]  s_axis_tuser,   // [2:0] kind, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] taken, [10:1] granted_id, [12:11] status
);

  fsm_e                  state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [IdW-1:0]        id_q, id_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       mark_q, mark_d;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic [AddrW-1:0]      rd_addr_q;
  logic                  rd_vld_q, rd_vld_d;
  logic [NumWords-1:0]   row_vld_q, row_vld_d;
  logic                  res_taken_q, res_taken_d;
  logic [IdW-1:0]        res_grant_q, res_grant_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_taken_q, out_taken_d;
  logic [IdW-1:0]        out_grant_q, out_grant_d;
  status_e               out_status_q, out_status_d;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  word_t                 ram_wdata;
  logic [AddrW-1:0]      ram_raddr;
  word_t                 ram_rdata;

  logic                  in_acc;
  kind_e                 in_kind;
  logic [IdW-1:0]        in_id;
  logic                  in_id_ok;
  logic                  pool_full;
  logic                  mark_top;
  word_t                 eff_word;
  logic                  cur_bit;
  word_t                 bit_mask;
  word_t                 low_word;
  logic                  low_hit;
  logic [BitW-1:0]       low_pos;
  logic                  high_hit;
  logic                  high_end;
  logic [BitW-1:0]       high_pos;
  logic                  resp_go;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_kind   = kind_e'(s_axis_tuser[KindW-1:0]);
  assign in_id     = s_axis_tdata[IdW-1:0];
  assign in_id_ok  = (CntW'(in_id) >= CntW'(MinId)) && (CntW'(in_id) < CntW'(MaxIds));
  assign pool_full = cnt_q >= CntW'(Cap);
  assign mark_top  = mark_q >= CntW'(MaxIds);

  // words never written since reset or clear read as all free
  assign eff_word  = row_vld_q[rd_addr_q] ? ram_rdata : '0;
  assign cur_bit   = eff_word[id_q[BitW-1:0]];
  assign bit_mask  = word_t'(1) << id_q[BitW-1:0];

  // shared word scanner: lowest free going up, highest taken going down
  assign low_word  = eff_word | below_min(rd_addr_q);
  assign low_hit   = rd_vld_q && (~low_word != '0);
  assign low_pos   = lowest_one(~low_word);
  assign high_hit  = rd_vld_q && (eff_word != '0);
  assign high_end  = rd_vld_q && (rd_addr_q == '0);
  assign high_pos  = highest_one(eff_word);

  assign resp_go   = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_QUERY, KIND_TAKE, KIND_FREE: state_d = in_id_ok ? S_EVAL : S_RESP;
            KIND_ALLOC: begin
              if (pool_full)     state_d = S_RESP;
              else if (mark_top) state_d = S_LOW;
              else               state_d = S_EVAL;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_EVAL: begin
        if (kind_q == KIND_ALLOC) state_d = cur_bit ? S_LOW : S_HIGH;
        else                      state_d = S_RESP;
      end
      S_LOW: begin
        if (low_hit) state_d = S_HIGH;
      end
      S_HIGH: begin
        if (high_hit || high_end) state_d = S_RESP;
      end
      S_RESP: begin
        if (resp_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d       = kind_q;
    id_d         = id_q;
    cnt_d        = cnt_q;
    mark_d       = mark_q;
    addr_d       = addr_q;
    rd_vld_d     = 1'b0;
    row_vld_d    = row_vld_q;
    res_taken_d  = res_taken_q;
    res_grant_d  = res_grant_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_taken_d  = out_taken_q;
    out_grant_d  = out_grant_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = rd_addr_q;
    ram_wdata    = eff_word | bit_mask;
    ram_raddr    = addr_q;

    case (state_q)
      S_IDLE: begin
        ram_raddr = (in_kind == KIND_ALLOC) ? mark_q[BitW+:AddrW] : in_id[BitW+:AddrW];
        if (in_acc) begin
          kind_d       = in_kind;
          id_d         = (in_kind == KIND_ALLOC) ? mark_q[IdW-1:0] : in_id;
          res_taken_d  = 1'b0;
          res_grant_d  = '0;
          res_status_d = STAT_OK;
          addr_d       = '0;
          case (in_kind)
            KIND_QUERY, KIND_TAKE, KIND_FREE: begin
              if (!in_id_ok) res_status_d = STAT_RANGE;
            end
            KIND_ALLOC: begin
              if (pool_full) res_status_d = STAT_FULL;
            end
            KIND_CLEAR: begin
              row_vld_d = '0;
              cnt_d     = '0;
              mark_d    = CntW'(MinId);
            end
            default: ;
          endcase
        end
      end
      S_EVAL: begin
        case (kind_q)
          KIND_QUERY: res_taken_d = cur_bit;
          KIND_TAKE: begin
            if (!cur_bit) begin
              ram_we               = 1'b1;
              row_vld_d[rd_addr_q] = 1'b1;
              cnt_d                = cnt_q + CntW'(1);
            end
          end
          KIND_FREE: begin
            if (cur_bit) begin
              ram_we               = 1'b1;
              ram_wdata            = eff_word & ~bit_mask;
              row_vld_d[rd_addr_q] = 1'b1;
              cnt_d                = cnt_q - CntW'(1);
            end
          end
          KIND_ALLOC: begin
            if (!cur_bit) begin
              ram_we               = 1'b1;
              row_vld_d[rd_addr_q] = 1'b1;
              cnt_d                = cnt_q + CntW'(1);
              res_grant_d          = id_q;
              addr_d               = AddrW'(NumWords - 1);
            end else begin
              addr_d = '0;
            end
          end
          default: ;
        endcase
      end
      S_LOW: begin
        if (low_hit) begin
          ram_we               = 1'b1;
          ram_wdata            = eff_word | (word_t'(1) << low_pos);
          row_vld_d[rd_addr_q] = 1'b1;
          cnt_d                = cnt_q + CntW'(1);
          res_grant_d          = {rd_addr_q, low_pos};
          addr_d               = AddrW'(NumWords - 1);
        end else begin
          rd_vld_d = 1'b1;
          addr_d   = addr_q + AddrW'(1);
        end
      end
      S_HIGH: begin
        if (high_hit) begin
          mark_d = CntW'({rd_addr_q, high_pos}) + CntW'(1);
        end else if (high_end) begin
          mark_d = CntW'(MinId);
        end else begin
          rd_vld_d = 1'b1;
          addr_d   = addr_q - AddrW'(1);
        end
      end
      S_RESP: begin
        if (resp_go) begin
          out_valid_d  = 1'b1;
          out_taken_d  = res_taken_q;
          out_grant_d  = res_grant_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mark_q      <= CntW'(MinId);
      rd_vld_q    <= 1'b0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mark_q      <= mark_d;
      rd_vld_q    <= rd_vld_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    id_q         <= id_d;
    addr_q       <= addr_d;
    rd_addr_q    <= ram_raddr;
    res_taken_q  <= res_taken_d;
    res_grant_q  <= res_grant_d;
    res_status_q <= res_status_d;
    out_taken_q  <= out_taken_d;
    out_grant_q  <= out_grant_d;
    out_status_q <= out_status_d;
  end

  bia_ram #(
    .Width (WordW),
    .Depth (NumWords)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_status_q, out_grant_q, out_taken_q};

`ifndef SYNTHESIS
  // the used count never goes past the pool size
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Cap))
    else $error("used count above pool capacity");

  // a clear transaction empties the pool
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_kind == KIND_CLEAR) |=> (cnt_q == '0 && row_vld_q == '0))
    else $error("clear did not empty the pool");

  // a full answer never carries an id
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STAT_FULL) |-> (out_grant_q == '0))
    else $error("full result with nonzero id");

  // the bitmap is only written while a transaction is being worked on
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EVAL || state_q == S_LOW))
    else $error("bitmap write outside update step");
`endif

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bitmap_id_allocator: a queue of operations drives
// the input stream with random gaps, a predictor with its own bitmap works out
// each reply, and a monitor with random stalls compares every reply field by
// field
// ----------------------------------------------------------------------------
module tb
  import bia_pkg::*;
;

  typedef struct packed {
    logic             hold;   // send only once every reply has come back
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   ident;
  } op_t;

  typedef struct packed {
    logic             taken;
    logic [IdW-1:0]   granted;
    logic [StatW-1:0] status;
  } reply_t;

  localparam int unsigned PoolCap = (MaxIds > MinId) ? MaxIds - MinId : 0;
  // kinds past the last operation code, they answer all zero
  localparam logic [KindW-1:0] KindSpareLo = KindW'(KIND_CLEAR) + 1'b1;
  localparam logic [KindW-1:0] KindSpareHi = '1;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [9:0] ident
  logic [7:0]  s_axis_tuser  = '0;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] taken, [10:1] granted_id, [12:11] status

  op_t    op_q[$];
  reply_t reply_q[$];
  op_t    cur_op     = '0;
  logic   drv_busy   = 1'b0;
  int     send_wait  = 0;
  int     recv_wait  = 0;
  int     send_calm  = 0;
  int     recv_calm  = 0;
  int     err_cnt    = 0;

  // predictor state
  logic [MaxIds-1:0] id_used  = '0;
  int unsigned       next_id  = MinId;
  int unsigned       used_ids = 0;

  bitmap_id_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit id_ok(int unsigned id);
    return id >= MinId && id < MaxIds;
  endfunction

  // updates the bitmap, count and next-id mark and returns the reply
  function automatic reply_t apply_op(op_t op);
    reply_t      r;
    int unsigned g;
    r = '0;
    r.status = STAT_OK;
    case (op.kind)
      KIND_QUERY: begin
        if (!id_ok(op.ident)) r.status = STAT_RANGE;
        else r.taken = id_used[op.ident];
      end
      KIND_TAKE: begin
        if (!id_ok(op.ident)) begin
          r.status = STAT_RANGE;
        end else if (!id_used[op.ident]) begin
          id_used[op.ident] = 1'b1;
          used_ids++;
        end
      end
      KIND_FREE: begin
        if (!id_ok(op.ident)) begin
          r.status = STAT_RANGE;
        end else if (id_used[op.ident]) begin
          id_used[op.ident] = 1'b0;
          used_ids--;
        end
      end
      KIND_ALLOC: begin
        if (used_ids >= PoolCap) begin
          r.status = STAT_FULL;
        end else begin
          g = next_id;
          // mark off the top or already taken: fall back to the lowest free id
          if (!id_ok(g) || id_used[g]) begin
            g = MinId;
            while (g < MaxIds && id_used[g]) g++;
          end
          id_used[g] = 1'b1;
          used_ids++;
          next_id = MinId;
          for (int i = int'(MaxIds) - 1; i >= int'(MinId); i--) begin
            if (id_used[i]) begin
              next_id = i + 1;
              break;
            end
          end
          r.granted = IdW'(g);
        end
      end
      KIND_CLEAR: begin
        id_used  = '0;
        used_ids = 0;
        next_id  = MinId;
      end
      default: ;
    endcase
    return r;
  endfunction

  // per-item wait, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_reply(logic [15:0] d);
    reply_t e;
    if (reply_q.size() == 0) begin
      report_mismatch($sformatf("reply with nothing pending, tdata=%h", d));
      return;
    end
    e = reply_q.pop_front();
    if (d[0] !== e.taken)
      report_mismatch($sformatf("taken got %0d want %0d", d[0], e.taken));
    if (d[10:1] !== e.granted)
      report_mismatch($sformatf("granted_id got %0d want %0d", d[10:1], e.granted));
    if (d[12:11] !== e.status)
      report_mismatch($sformatf("status got %0d want %0d", d[12:11], e.status));
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        reply_q.push_back(apply_op(cur_op));
        drv_busy = 1'b0;
      end
      if (!drv_busy && op_q.size() > 0) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (!(op_q[0].hold && reply_q.size() > 0)) begin
          cur_op    = op_q.pop_front();
          drv_busy  = 1'b1;
          send_wait = draw_wait(send_calm);
        end
      end
      s_axis_tvalid <= drv_busy;
      s_axis_tdata  <= 16'(cur_op.ident);
      s_axis_tuser  <= 8'(cur_op.kind);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply(m_axis_tdata);
        recv_wait = draw_wait(recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_axis_tready <= (recv_wait == 0);
    end
  end

  task automatic add_op(logic [KindW-1:0] kind, logic [IdW-1:0] ident, logic hold = 1'b0);
    op_t op;
    op.hold  = hold;
    op.kind  = kind;
    op.ident = ident;
    op_q.push_back(op);
  endtask

  // mostly a low window where allocation lands, plus edges and full range
  function automatic logic [IdW-1:0] pick_ident();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return IdW'($urandom_range(MinId, MinId + 47));
    if (sel < 75) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return IdW'(MinId);
        2:       return '1;
        default: return IdW'(MaxIds - 1);
      endcase
    end
    return IdW'($urandom);
  endfunction

  function automatic logic [KindW-1:0] pick_kind();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return KIND_QUERY;
    if (sel < 40) return KIND_TAKE;
    if (sel < 58) return KIND_FREE;
    if (sel < 92) return KIND_ALLOC;
    if (sel < 95) return KIND_CLEAR;
    return KindW'($urandom_range(KindSpareLo, KindSpareHi));
  endfunction

  initial begin
    // directed: range edges, repeated marks, mark at the top, mark on a taken id
    add_op(KIND_QUERY, '0, 1'b1);
    add_op(KIND_QUERY, IdW'(MaxIds - 1));
    add_op(KIND_TAKE, '0);
    add_op(KIND_FREE, IdW'(MaxIds - 1));
    add_op(KIND_TAKE, IdW'(MaxIds - 1));
    add_op(KIND_TAKE, IdW'(MaxIds - 1));
    add_op(KIND_QUERY, IdW'(MaxIds - 1));
    add_op(KIND_ALLOC, '0);
    add_op(KIND_ALLOC, '1);
    add_op(KIND_FREE, IdW'(MaxIds - 1));
    add_op(KIND_ALLOC, '0);
    add_op(KIND_TAKE, IdW'(MinId + 3));
    add_op(KIND_ALLOC, '0);
    add_op(KIND_FREE, '0);
    add_op(KIND_QUERY, 10'h2aa);
    add_op(KIND_TAKE, 10'h155);
    add_op(KindSpareLo, '1);
    add_op(KindSpareLo + 1'b1, '0);
    add_op(KindSpareHi, 10'h155);
    add_op(KIND_CLEAR, '1);
    add_op(KIND_QUERY, IdW'(MinId));
    add_op(KIND_ALLOC, '0);
    add_op(KIND_FREE, IdW'(MinId));
    add_op(KIND_ALLOC, '0);
    add_op(KIND_CLEAR, '0);

    // random mix of all operations
    for (int n = 0; n < 100; n++)
      add_op(pick_kind(), pick_ident(), $urandom_range(0, 59) == 0);

    // fill the pool: distinct high ids marked directly, then allocate to full
    add_op(KIND_CLEAR, pick_ident(), 1'b1);
    for (int k = 0; k < 30; k++)
      add_op(KIND_TAKE, IdW'(512 + 16 * k + $urandom_range(0, 15)));
    for (int n = 0; n < 1000; n++) begin
      add_op(KIND_ALLOC, IdW'($urandom));
      if ($urandom_range(0, 31) == 0) add_op(KIND_QUERY, IdW'($urandom));
    end
    // open holes and take them back through the lowest-free search
    for (int k = 0; k < 12; k++)
      add_op(KIND_FREE, IdW'(MinId + 80 * k + $urandom_range(0, 79)));
    for (int n = 0; n < 16; n++)
      add_op(KIND_ALLOC, IdW'($urandom));
    add_op(KIND_QUERY, '1);
    add_op(KIND_CLEAR, IdW'($urandom));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() > 0 || drv_busy || reply_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> bitmap_id_allocator.f
rtl/bia_pkg.sv
rtl/bia_ram.sv
rtl/bitmap_id_allocator.sv
verif/tb.sv
